/* src/synth_voice_allocator_unit_macros.svh */
// Assertion helpers shared by the allocator RTL.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef SYNTH_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// A property that must hold at every edge.
`define SVAU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A property that must hold in the cycle after its trigger.
`define SVAU_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/svalloc_pkg.sv */
package svalloc_pkg;

  // Sizing of the voice slots, the held-note stack and the age counters.
  localparam int MAX_SLOTS  = 8;
  localparam int HELD_DEPTH = 128;
  localparam int AGE_BITS   = 32;

  // Field widths fixed by the interface.
  localparam int NOTE_W      = 7;
  localparam int KIND_W      = 2;
  localparam int PC_W        = 4;
  localparam int IDX_OUT_W   = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELDS_W = 1 + IDX_OUT_W + 1 + NOTE_W + 1 + NOTE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Derived widths.
  localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int HELD_AW    = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int HELD_CW    = $clog2(HELD_DEPTH + 1);
  localparam int VOICE_W    = NOTE_W + AGE_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MONO_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POLY_COUNT = CFG_IDX_W'(1);

  // Event kinds on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_TICK     = 2'd2
  } kind_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_TK_RD,
    S_TK_WR,
    S_ST_RD,
    S_ST_CMP,
    S_OFF_RD,
    S_OFF_CMP,
    S_HS_RD,
    S_HS_CMP,
    S_SH_RD,
    S_SH_WR,
    S_POST_RM,
    S_PUSH,
    S_TOP_RD,
    S_TOP_WAIT,
    S_SLOT_WR,
    S_RESULT
  } state_t;

endpackage

/* src/svalloc_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data.
module svalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/synth_voice_allocator_unit.sv */
// Channel   Ports                             Contents
// in        in_tvalid/in_tready               in_tuser: kind; in_tdata: note
// out       out_tvalid/out_tready             out_tdata: one allocation result per event
// cfg       cfg_valid/cfg_ready               cfg_index, cfg_data: register write
//
// One event is processed at a time by a sequencer around two RAMs (voice note/age
// and the held-note stack); each RAM entry visited takes a read state and then a
// compare or write state. A tick visits every slot; a poly note-on to a free slot
// goes straight to the slot write, while stealing and poly note-off search the slots
// in use. Mono events walk the stack. Reset (rst_n, synchronous) clears the active
// flags and the stack count at once, so no clearing pass is needed. A stalled output
// holds one finished result while the next event is taken; a second result waits in
// the sequencer.
`include "synth_voice_allocator_unit_macros.svh"

module synth_voice_allocator_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input events
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [svalloc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [6:0] note
  input  logic [svalloc_pkg::KIND_W-1:0]         in_tuser,   // [1:0] kind
  // Results
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [0] changed, [3:1] slot_index, [4] slot_active, [11:5] slot_note,
  // [12] stolen, [19:13] stolen_note
  output logic [svalloc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [svalloc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svalloc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [svalloc_pkg::AGE_BITS-1:0] AGE_MAX = '1;

  // Control and working registers.
  svalloc_pkg::state_t state_r, state_nxt;
  logic                                   mono_mode_r, mono_mode_nxt;
  logic [svalloc_pkg::PC_W-1:0]           poly_count_r, poly_count_nxt;
  logic [svalloc_pkg::MAX_SLOTS-1:0]      active_r, active_nxt;
  logic [svalloc_pkg::HELD_CW-1:0]        held_cnt_r, held_cnt_nxt;
  logic [svalloc_pkg::HELD_CW-1:0]        held_idx_r, held_idx_nxt;
  logic [svalloc_pkg::SLOT_CNT_W-1:0]     slot_idx_r, slot_idx_nxt;
  logic                                   is_on_r, is_on_nxt;
  logic                                   found_r, found_nxt;
  logic [svalloc_pkg::NOTE_W-1:0]         note_r, note_nxt;
  logic [svalloc_pkg::NOTE_W-1:0]         wnote_r, wnote_nxt;
  logic [svalloc_pkg::SLOT_W-1:0]         wslot_r, wslot_nxt;
  logic [svalloc_pkg::AGE_BITS-1:0]       best_age_r, best_age_nxt;
  logic                                   res_changed_r, res_changed_nxt;
  logic [svalloc_pkg::SLOT_W-1:0]         res_slot_r, res_slot_nxt;
  logic                                   res_active_r, res_active_nxt;
  logic [svalloc_pkg::NOTE_W-1:0]         res_note_r, res_note_nxt;
  logic                                   res_stolen_r, res_stolen_nxt;
  logic [svalloc_pkg::NOTE_W-1:0]         res_snote_r, res_snote_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  logic [svalloc_pkg::OUT_TDATA_W-1:0]    out_tdata_r, out_tdata_nxt;

  // RAM ports.
  logic                                   v_we;
  logic [svalloc_pkg::SLOT_W-1:0]         v_waddr, v_raddr;
  logic [svalloc_pkg::VOICE_W-1:0]        v_wdata, v_rdata;
  logic                                   h_we;
  logic [svalloc_pkg::HELD_AW-1:0]        h_waddr, h_raddr;
  logic [svalloc_pkg::NOTE_W-1:0]         h_wdata, h_rdata;

  // Shared decode.
  logic                                   in_xfer;
  logic                                   cfg_xfer;
  logic                                   out_free;
  logic [svalloc_pkg::SLOT_CNT_W-1:0]     n_eff;
  logic                                   free_found;
  logic [svalloc_pkg::SLOT_W-1:0]         free_slot;
  logic [svalloc_pkg::SLOT_W-1:0]         slot_sel;
  logic                                   slot_end;
  logic                                   tick_end;
  logic                                   held_end;
  logic [svalloc_pkg::HELD_CW:0]          held_nx;
  logic                                   shift_end;
  logic                                   stack_full;
  logic [svalloc_pkg::NOTE_W-1:0]         v_rnote;
  logic [svalloc_pkg::AGE_BITS-1:0]       v_rage;
  logic [svalloc_pkg::AGE_BITS-1:0]       v_age_inc;
  logic [svalloc_pkg::NOTE_W-1:0]         in_note;
  logic [svalloc_pkg::HELD_CW-1:0]        held_top;

  // Voice note and age store.
  svalloc_ram #(
    .WIDTH (svalloc_pkg::VOICE_W),
    .DEPTH (svalloc_pkg::MAX_SLOTS)
  ) u_voice_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Held-note stack, bottom at entry 0.
  svalloc_ram #(
    .WIDTH (svalloc_pkg::NOTE_W),
    .DEPTH (svalloc_pkg::HELD_DEPTH)
  ) u_held_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Handshakes: configuration wins over a new event in the idle state.
  assign cfg_ready  = (state_r == svalloc_pkg::S_IDLE);
  assign in_tready  = (state_r == svalloc_pkg::S_IDLE) && !cfg_valid;
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign in_note    = in_tdata[svalloc_pkg::NOTE_W-1:0];

  // Effective number of poly slots: zero acts as one, large values clamp.
  always_comb begin
    if (poly_count_r == '0) begin
      n_eff = svalloc_pkg::SLOT_CNT_W'(1);
    end else if (int'(poly_count_r) > svalloc_pkg::MAX_SLOTS) begin
      n_eff = svalloc_pkg::SLOT_CNT_W'(svalloc_pkg::MAX_SLOTS);
    end else begin
      n_eff = svalloc_pkg::SLOT_CNT_W'(poly_count_r);
    end
  end

  // Lowest free slot among the slots in use.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = svalloc_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i] && (i < int'(n_eff))) begin
        free_found = 1'b1;
        free_slot  = svalloc_pkg::SLOT_W'(i);
      end
    end
  end

  // Loop bounds and read-data fields.
  assign slot_sel   = slot_idx_r[svalloc_pkg::SLOT_W-1:0];
  assign slot_end   = (slot_idx_r == n_eff);
  assign tick_end   = (slot_idx_r == svalloc_pkg::SLOT_CNT_W'(svalloc_pkg::MAX_SLOTS));
  assign held_end   = (held_idx_r == held_cnt_r);
  assign held_nx    = {1'b0, held_idx_r} + 1'b1;
  assign shift_end  = (held_nx >= {1'b0, held_cnt_r});
  assign stack_full = (held_cnt_r == svalloc_pkg::HELD_CW'(svalloc_pkg::HELD_DEPTH));
  assign held_top   = held_cnt_r - 1'b1;
  assign v_rnote    = v_rdata[svalloc_pkg::AGE_BITS +: svalloc_pkg::NOTE_W];
  assign v_rage     = v_rdata[svalloc_pkg::AGE_BITS-1:0];
  assign v_age_inc  = (active_r[slot_sel] && (v_rage != AGE_MAX)) ? v_rage + 1'b1 : v_rage;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svalloc_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (in_tuser)
            svalloc_pkg::KIND_TICK: state_nxt = svalloc_pkg::S_TK_RD;
            svalloc_pkg::KIND_NOTE_ON: begin
              if (mono_mode_r) begin
                state_nxt = svalloc_pkg::S_HS_RD;
              end else if (free_found) begin
                state_nxt = svalloc_pkg::S_SLOT_WR;
              end else begin
                state_nxt = svalloc_pkg::S_ST_RD;
              end
            end
            svalloc_pkg::KIND_NOTE_OFF: begin
              state_nxt = mono_mode_r ? svalloc_pkg::S_HS_RD : svalloc_pkg::S_OFF_RD;
            end
            default: state_nxt = svalloc_pkg::S_RESULT;
          endcase
        end
      end
      svalloc_pkg::S_TK_RD:
        state_nxt = tick_end ? svalloc_pkg::S_RESULT : svalloc_pkg::S_TK_WR;
      svalloc_pkg::S_TK_WR:
        state_nxt = svalloc_pkg::S_TK_RD;
      svalloc_pkg::S_ST_RD:
        state_nxt = slot_end ? svalloc_pkg::S_SLOT_WR : svalloc_pkg::S_ST_CMP;
      svalloc_pkg::S_ST_CMP:
        state_nxt = svalloc_pkg::S_ST_RD;
      svalloc_pkg::S_OFF_RD:
        state_nxt = slot_end ? svalloc_pkg::S_RESULT : svalloc_pkg::S_OFF_CMP;
      svalloc_pkg::S_OFF_CMP: begin
        if (active_r[slot_sel] && (v_rnote == note_r)) begin
          state_nxt = svalloc_pkg::S_RESULT;
        end else begin
          state_nxt = svalloc_pkg::S_OFF_RD;
        end
      end
      svalloc_pkg::S_HS_RD:
        state_nxt = held_end ? svalloc_pkg::S_POST_RM : svalloc_pkg::S_HS_CMP;
      svalloc_pkg::S_HS_CMP:
        state_nxt = (h_rdata == note_r) ? svalloc_pkg::S_SH_RD : svalloc_pkg::S_HS_RD;
      svalloc_pkg::S_SH_RD:
        state_nxt = shift_end ? svalloc_pkg::S_POST_RM : svalloc_pkg::S_SH_WR;
      svalloc_pkg::S_SH_WR:
        state_nxt = svalloc_pkg::S_SH_RD;
      svalloc_pkg::S_POST_RM: begin
        if (is_on_r) begin
          state_nxt = stack_full ? svalloc_pkg::S_SH_RD : svalloc_pkg::S_PUSH;
        end else if (found_r && (held_cnt_r != '0)) begin
          state_nxt = svalloc_pkg::S_TOP_RD;
        end else begin
          state_nxt = svalloc_pkg::S_RESULT;
        end
      end
      svalloc_pkg::S_PUSH:     state_nxt = svalloc_pkg::S_SLOT_WR;
      svalloc_pkg::S_TOP_RD:   state_nxt = svalloc_pkg::S_TOP_WAIT;
      svalloc_pkg::S_TOP_WAIT: state_nxt = svalloc_pkg::S_SLOT_WR;
      svalloc_pkg::S_SLOT_WR:  state_nxt = svalloc_pkg::S_RESULT;
      svalloc_pkg::S_RESULT:
        state_nxt = out_free ? svalloc_pkg::S_IDLE : svalloc_pkg::S_RESULT;
      default: state_nxt = svalloc_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result register.
  always_comb begin
    mono_mode_nxt   = mono_mode_r;
    poly_count_nxt  = poly_count_r;
    active_nxt      = active_r;
    held_cnt_nxt    = held_cnt_r;
    held_idx_nxt    = held_idx_r;
    slot_idx_nxt    = slot_idx_r;
    is_on_nxt       = is_on_r;
    found_nxt       = found_r;
    note_nxt        = note_r;
    wnote_nxt       = wnote_r;
    wslot_nxt       = wslot_r;
    best_age_nxt    = best_age_r;
    res_changed_nxt = res_changed_r;
    res_slot_nxt    = res_slot_r;
    res_active_nxt  = res_active_r;
    res_note_nxt    = res_note_r;
    res_stolen_nxt  = res_stolen_r;
    res_snote_nxt   = res_snote_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;

    v_we    = 1'b0;
    v_waddr = slot_sel;
    v_wdata = {v_rnote, v_age_inc};
    v_raddr = slot_sel;
    h_we    = 1'b0;
    h_waddr = held_idx_r[svalloc_pkg::HELD_AW-1:0];
    h_wdata = h_rdata;
    h_raddr = held_idx_r[svalloc_pkg::HELD_AW-1:0];

    unique case (state_r)
      // Capture the event and clear the result fields.
      svalloc_pkg::S_IDLE: begin
        if (in_xfer) begin
          note_nxt        = in_note;
          wnote_nxt       = in_note;
          wslot_nxt       = free_slot;
          is_on_nxt       = (in_tuser == svalloc_pkg::KIND_NOTE_ON);
          found_nxt       = 1'b0;
          slot_idx_nxt    = '0;
          held_idx_nxt    = '0;
          res_changed_nxt = 1'b0;
          res_slot_nxt    = '0;
          res_active_nxt  = 1'b0;
          res_note_nxt    = '0;
          res_stolen_nxt  = 1'b0;
          res_snote_nxt   = '0;
          if (mono_mode_r) begin
            wslot_nxt = '0;
          end
        end
      end
      // Age every active slot, saturating.
      svalloc_pkg::S_TK_WR: begin
        v_we         = 1'b1;
        slot_idx_nxt = slot_idx_r + 1'b1;
      end
      // Steal search: oldest active slot, lowest index on a tie.
      svalloc_pkg::S_ST_RD: begin
        if (slot_end) begin
          res_stolen_nxt = 1'b1;
        end
      end
      svalloc_pkg::S_ST_CMP: begin
        if ((slot_idx_r == '0) || (v_rage > best_age_r)) begin
          best_age_nxt  = v_rage;
          wslot_nxt     = slot_sel;
          res_snote_nxt = v_rnote;
        end
        slot_idx_nxt = slot_idx_r + 1'b1;
      end
      // Poly note-off: free the lowest slot holding the note.
      svalloc_pkg::S_OFF_CMP: begin
        if (active_r[slot_sel] && (v_rnote == note_r)) begin
          active_nxt[slot_sel] = 1'b0;
          res_changed_nxt      = 1'b1;
          res_slot_nxt         = slot_sel;
        end else begin
          slot_idx_nxt = slot_idx_r + 1'b1;
        end
      end
      // Stack search for the note.
      svalloc_pkg::S_HS_CMP: begin
        if (h_rdata == note_r) begin
          found_nxt = 1'b1;
        end else begin
          held_idx_nxt = held_idx_r + 1'b1;
        end
      end
      // Close the gap: move the entry above down by one.
      svalloc_pkg::S_SH_RD: begin
        h_raddr = held_nx[svalloc_pkg::HELD_AW-1:0];
        if (shift_end) begin
          held_cnt_nxt = held_cnt_r - 1'b1;
        end
      end
      svalloc_pkg::S_SH_WR: begin
        h_we         = 1'b1;
        held_idx_nxt = svalloc_pkg::HELD_CW'(held_nx);
      end
      // After removal: push (dropping the bottom when full), new top, or free slot 0.
      svalloc_pkg::S_POST_RM: begin
        if (is_on_r) begin
          held_idx_nxt = '0;
        end else if (found_r && (held_cnt_r == '0)) begin
          active_nxt[0]   = 1'b0;
          res_changed_nxt = 1'b1;
          res_slot_nxt    = '0;
        end
      end
      svalloc_pkg::S_PUSH: begin
        h_we         = 1'b1;
        h_waddr      = held_cnt_r[svalloc_pkg::HELD_AW-1:0];
        h_wdata      = note_r;
        held_cnt_nxt = held_cnt_r + 1'b1;
      end
      svalloc_pkg::S_TOP_RD: begin
        h_raddr = held_top[svalloc_pkg::HELD_AW-1:0];
      end
      svalloc_pkg::S_TOP_WAIT: begin
        wnote_nxt = h_rdata;
      end
      // Start a voice: new note, age zero.
      svalloc_pkg::S_SLOT_WR: begin
        v_we                = 1'b1;
        v_waddr             = wslot_r;
        v_wdata             = {wnote_r, {svalloc_pkg::AGE_BITS{1'b0}}};
        active_nxt[wslot_r] = 1'b1;
        res_changed_nxt     = 1'b1;
        res_slot_nxt        = wslot_r;
        res_active_nxt      = 1'b1;
        res_note_nxt        = wnote_r;
      end
      // Hand the result to the output register.
      svalloc_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {{(svalloc_pkg::OUT_TDATA_W - svalloc_pkg::OUT_FIELDS_W){1'b0}},
                           res_snote_r, res_stolen_r, res_note_r, res_active_r,
                           svalloc_pkg::IDX_OUT_W'(res_slot_r), res_changed_r};
        end
      end
      default: begin
      end
    endcase

    // A write to either defined register clears all voices and the stack.
    if (cfg_xfer) begin
      unique case (cfg_index)
        svalloc_pkg::REG_MONO_MODE: begin
          mono_mode_nxt = cfg_data[0];
          active_nxt    = '0;
          held_cnt_nxt  = '0;
        end
        svalloc_pkg::REG_POLY_COUNT: begin
          poly_count_nxt = cfg_data[svalloc_pkg::PC_W-1:0];
          active_nxt     = '0;
          held_cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= svalloc_pkg::S_IDLE;
      mono_mode_r  <= 1'b0;
      poly_count_r <= svalloc_pkg::PC_W'(8);
      active_r     <= '0;
      held_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mono_mode_r  <= mono_mode_nxt;
      poly_count_r <= poly_count_nxt;
      active_r     <= active_nxt;
      held_cnt_r   <= held_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    held_idx_r    <= held_idx_nxt;
    slot_idx_r    <= slot_idx_nxt;
    is_on_r       <= is_on_nxt;
    found_r       <= found_nxt;
    note_r        <= note_nxt;
    wnote_r       <= wnote_nxt;
    wslot_r       <= wslot_nxt;
    best_age_r    <= best_age_nxt;
    res_changed_r <= res_changed_nxt;
    res_slot_r    <= res_slot_nxt;
    res_active_r  <= res_active_nxt;
    res_note_r    <= res_note_nxt;
    res_stolen_r  <= res_stolen_nxt;
    res_snote_r   <= res_snote_nxt;
    out_tdata_r   <= out_tdata_nxt;
  end

  // Checks on the allocator state.
  `SVAU_CHECK(a_held_bound, held_cnt_r <= svalloc_pkg::HELD_CW'(svalloc_pkg::HELD_DEPTH), "held count above stack depth")
  `SVAU_CHECK(a_mono_one_voice, !mono_mode_r || ((active_r >> 1) == '0), "mono mode has a voice above slot 0")
  `SVAU_CHECK(a_poly_in_range, mono_mode_r || ((active_r >> n_eff) == '0), "active voice beyond poly count")
  `SVAU_CHECK_NEXT(a_one_event, in_tvalid && in_tready, !in_tready, "event taken while another is in work")
  `SVAU_CHECK_NEXT(a_cfg_clears, cfg_valid && cfg_ready && ((cfg_index == svalloc_pkg::REG_MONO_MODE) || (cfg_index == svalloc_pkg::REG_POLY_COUNT)), (active_r == '0) && (held_cnt_r == '0), "register write did not clear voices")

endmodule

/* bench/tb_synth_voice_allocator_unit.sv */
`timescale 1ns / 100ps

module tb_synth_voice_allocator_unit;
  import svalloc_pkg::*;

  // Run control.
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 500;

  // Input kind with no defined meaning; the block must answer with all zeros.
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note;
  } voice_event_t;

  // One allocation result, last field in the lowest bits.
  typedef struct packed {
    logic [NOTE_W-1:0]    stolen_note;
    logic                 stolen;
    logic [NOTE_W-1:0]    slot_note;
    logic                 slot_active;
    logic [IDX_OUT_W-1:0] slot_index;
    logic                 changed;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // [6:0] note
  logic [KIND_W-1:0] in_tuser = '0;       // [1:0] kind
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [0] changed, [3:1] slot_index, [4] slot_active, [11:5] slot_note,
  // [12] stolen, [19:13] stolen_note
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  synth_voice_allocator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the allocator state and its registers.
  logic                mono_sel = 1'b0;
  logic [PC_W-1:0]     poly_cnt = PC_W'(8);
  logic                voice_on  [MAX_SLOTS];
  logic [NOTE_W-1:0]   voice_nt  [MAX_SLOTS];
  logic [AGE_BITS-1:0] voice_age [MAX_SLOTS];
  logic [NOTE_W-1:0]   held_stack[$];

  voice_event_t  pending_events[$];
  alloc_result_t expected_allocs[$];

  int unsigned fail_cnt = 0;
  int unsigned cnt_on = 0, cnt_off = 0, cnt_tick = 0, cnt_unknown = 0;
  int unsigned cnt_steal = 0, cnt_reg_writes = 0, deepest_stack = 0;

  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;

  function automatic void clear_voices();
    foreach (voice_on[i]) begin
      voice_on[i] = 1'b0;
      voice_nt[i] = '0;
      voice_age[i] = '0;
    end
    held_stack.delete();
  endfunction

  // Writes one slot of the shadow state and reports it as the result.
  function automatic alloc_result_t take_slot(int s, logic act, logic [NOTE_W-1:0] nt);
    alloc_result_t r = '0;
    voice_on[s] = act;
    voice_nt[s] = act ? nt : '0;
    voice_age[s] = '0;
    r.changed = 1'b1;
    r.slot_index = IDX_OUT_W'(s);
    r.slot_active = act;
    r.slot_note = act ? nt : '0;
    return r;
  endfunction

  // Applies one event to the shadow state and returns the allocation it must cause.
  function automatic alloc_result_t predict_allocation(voice_event_t ev);
    alloc_result_t r = '0;
    int n;
    int pick;
    int hit;
    logic [NOTE_W-1:0] old_note;

    if (poly_cnt == 0) n = 1;
    else if (poly_cnt > MAX_SLOTS) n = MAX_SLOTS;
    else n = poly_cnt;

    case (ev.kind)
      KIND_TICK: begin
        cnt_tick++;
        foreach (voice_on[i])
          if (voice_on[i] && voice_age[i] != '1) voice_age[i]++;
      end
      KIND_NOTE_ON: begin
        cnt_on++;
        if (mono_sel) begin
          // Last-note priority: a held note moves to the top.
          hit = -1;
          foreach (held_stack[i])
            if (hit < 0 && held_stack[i] == ev.note) hit = i;
          if (hit >= 0) held_stack.delete(hit);
          if (held_stack.size() >= HELD_DEPTH) void'(held_stack.pop_front());
          held_stack.push_back(ev.note);
          if (held_stack.size() > deepest_stack) deepest_stack = held_stack.size();
          r = take_slot(0, 1'b1, ev.note);
        end else begin
          for (int i = 0; i < n; i++)
            if (!voice_on[i]) return take_slot(i, 1'b1, ev.note);
          // Every slot sounds: the oldest one is stolen, lowest index on a tie.
          pick = 0;
          for (int i = 1; i < n; i++)
            if (voice_age[i] > voice_age[pick]) pick = i;
          old_note = voice_nt[pick];
          r = take_slot(pick, 1'b1, ev.note);
          r.stolen = 1'b1;
          r.stolen_note = old_note;
          cnt_steal++;
        end
      end
      KIND_NOTE_OFF: begin
        cnt_off++;
        if (mono_sel) begin
          hit = -1;
          foreach (held_stack[i])
            if (hit < 0 && held_stack[i] == ev.note) hit = i;
          if (hit >= 0) begin
            held_stack.delete(hit);
            if (held_stack.size() == 0) r = take_slot(0, 1'b0, '0);
            else r = take_slot(0, 1'b1, held_stack[$]);
          end
        end else begin
          for (int i = 0; i < n; i++) begin
            if (voice_on[i] && voice_nt[i] == ev.note) begin
              r = take_slot(i, 1'b0, '0);
              break;
            end
          end
        end
      end
      default: cnt_unknown++;
    endcase
    return r;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      fail_cnt++;
    end
  endfunction

  // Sender: offers queued events, with random gaps and calm stretches.
  voice_event_t cur_ev;
  int unsigned in_gap = 0;
  int unsigned send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // A transfer took place at this edge: predict its result.
      if (in_tvalid) expected_allocs.push_back(predict_allocation(cur_ev));
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        cur_ev = pending_events.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= IN_TDATA_W'(cur_ev.note);
        in_tuser <= cur_ev.kind;
        if (send_calm > 0) begin
          send_calm--;
          in_gap = 0;
        end else if ($urandom_range(0, 99) < 4) begin
          send_calm = $urandom_range(20, 60);
          in_gap = 0;
        end else if ($urandom_range(0, 99) < 55) begin
          in_gap = 0;
        end else begin
          in_gap = idle_len();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver readiness: random stalls, calm stretches and one long hold-off.
  int unsigned hold_left = 0;
  int unsigned ready_calm = 0;
  int unsigned ready_stall = 0;

  always @(posedge clk) begin
    int unsigned r;
    if (hold_off_req && !hold_off_done) begin
      hold_left = LONG_HOLD;
      hold_off_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (ready_calm > 0) begin
      ready_calm--;
      out_tready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall--;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        ready_calm = $urandom_range(100, 300);
        out_tready <= 1'b1;
      end else if (r < 70) begin
        out_tready <= 1'b1;
      end else begin
        ready_stall = idle_len() - 1;
        out_tready <= 1'b0;
      end
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_FIELDS_W-1:0];
      if (expected_allocs.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_tdata);
        fail_cnt++;
      end else begin
        want = expected_allocs.pop_front();
        check_field("changed", want.changed, got.changed);
        check_field("slot_index", want.slot_index, got.slot_index);
        check_field("slot_active", want.slot_active, got.slot_active);
        check_field("slot_note", want.slot_note, got.slot_note);
        check_field("stolen", want.stolen, got.stolen);
        check_field("stolen_note", want.stolen_note, got.stolen_note);
      end
    end
  end

  // Watchdog.
  int unsigned cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_allocs.size());
      $display("synth_voice_allocator_unit test failed");
      $finish;
    end
  end

  task automatic push_event(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note);
    voice_event_t ev;
    ev.kind = kind;
    ev.note = note;
    pending_events.push_back(ev);
  endtask

  // Waits until every event is sent and answered, then lets the block settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_tvalid || expected_allocs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write on the configuration channel; the shadow state follows.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MONO_MODE) mono_sel = val[0];
    else if (idx == REG_POLY_COUNT) poly_cnt = val;
    clear_voices();
    cnt_reg_writes++;
  endtask

  // Random events drawn mostly from a small pool of notes, so that note-offs
  // and re-triggers hit sounding voices; the rest is full-range noise.
  task automatic queue_random(int unsigned count);
    logic [NOTE_W-1:0] pool[16];
    int unsigned pool_n;
    int unsigned r;
    pool_n = $urandom_range(3, 16);
    foreach (pool[i]) pool[i] = NOTE_W'($urandom_range(0, 127));
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 45) push_event(KIND_NOTE_ON, pool[$urandom_range(0, pool_n - 1)]);
      else if (r < 77) push_event(KIND_NOTE_OFF, pool[$urandom_range(0, pool_n - 1)]);
      else if (r < 91) push_event(KIND_TICK, NOTE_W'($urandom_range(0, 127)));
      else if (r < 94) push_event(KIND_NOTE_ON, NOTE_W'($urandom_range(0, 127)));
      else if (r < 97) push_event(KIND_NOTE_OFF, NOTE_W'($urandom_range(0, 127)));
      else push_event(KIND_UNKNOWN, NOTE_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int order[HELD_DEPTH];
    int j;
    int t;

    clear_voices();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: extremes of the note, a missed note-off, an unknown kind.
    push_event(KIND_NOTE_ON, 7'd0);
    push_event(KIND_NOTE_ON, 7'd127);
    push_event(KIND_TICK, 7'd127);
    push_event(KIND_NOTE_OFF, 7'd42);
    push_event(KIND_NOTE_OFF, 7'd127);
    push_event(KIND_UNKNOWN, 7'd127);
    push_event(KIND_TICK, 7'd0);

    // Two voices: steal the older one, then steal on an age tie.
    write_reg(REG_POLY_COUNT, 4'd2);
    push_event(KIND_NOTE_ON, 7'd10);
    push_event(KIND_TICK, 7'd0);
    push_event(KIND_NOTE_ON, 7'd20);
    push_event(KIND_NOTE_ON, 7'd30);
    push_event(KIND_NOTE_ON, 7'd40);

    // Mono: re-trigger moves to top, release falls back, unheld release ignored.
    write_reg(REG_MONO_MODE, 4'd1);
    push_event(KIND_NOTE_ON, 7'd60);
    push_event(KIND_NOTE_ON, 7'd61);
    push_event(KIND_NOTE_ON, 7'd60);
    push_event(KIND_NOTE_OFF, 7'd60);
    push_event(KIND_NOTE_OFF, 7'd99);
    push_event(KIND_NOTE_OFF, 7'd61);
    push_event(KIND_TICK, 7'd0);

    // Random phases over several register settings.
    write_reg(REG_MONO_MODE, 4'd0);
    write_reg(REG_POLY_COUNT, 4'd0);
    queue_random(90);

    write_reg(REG_POLY_COUNT, 4'd15);
    hold_off_req = 1'b1;
    queue_random(100);

    write_reg(REG_POLY_COUNT, 4'd3);
    queue_random(90);

    write_reg(REG_MONO_MODE, 4'd1);
    queue_random(90);

    // Fill the held-note stack with every note, then run random events on the full stack.
    write_reg(REG_MONO_MODE, 4'd1);
    foreach (order[i]) order[i] = i;
    for (int i = HELD_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) push_event(KIND_NOTE_ON, NOTE_W'(order[i]));
    queue_random(40);

    write_reg(REG_MONO_MODE, 4'd0);
    queue_random(90);

    write_reg(REG_POLY_COUNT, 4'd8);
    queue_random(90);

    write_reg(REG_POLY_COUNT, 4'd1);
    queue_random(60);

    write_reg(REG_POLY_COUNT, 4'd9);
    queue_random(80);

    drain();
    if (expected_allocs.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_allocs.size());
      fail_cnt++;
    end

    $display("Covered %0d events: %0d note-on, %0d note-off, %0d tick, %0d unknown kind.",
             cnt_on + cnt_off + cnt_tick + cnt_unknown, cnt_on, cnt_off, cnt_tick,
             cnt_unknown);
    $display("%0d register writes, %0d voice steals, held stack up to %0d notes deep.",
             cnt_reg_writes, cnt_steal, deepest_stack);
    if (fail_cnt == 0) begin
      $display("synth_voice_allocator_unit test passed");
    end else begin
      $display("synth_voice_allocator_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/svalloc_pkg.sv
src/svalloc_ram.sv
src/synth_voice_allocator_unit.sv
bench/tb_synth_voice_allocator_unit.sv
